// ===== rtl/core/sdds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine DDS oscillator package
// Shared constants, register indexes and the stage-to-stage control type.
// ----------------------------------------------------------------------------
package sdds_pkg;

    // Default sizes for the top-level parameters.
    localparam int PHASE_BITS_DEF  = 32;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths of the register file and the sine table.
    localparam int STEP_W = 32;
    localparam int GAIN_W = 16;
    localparam int CFG_W  = 32;
    localparam int SINE_W = 15;

    // Reset value of the gain register: unity in Q1.15.
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

    // pi/2 in Q2.30, used to build the quarter-wave table.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        REG_PHASE_STEP = 1'b0,
        REG_AMP_GAIN   = 1'b1
    } sdds_reg_t;

    // Control that travels along the chain of cells with each frame.
    typedef struct packed {
        logic valid;
        logic last;
    } sdds_ctl_t;

endpackage

// ===== rtl/core/sine_dds_oscillator.sv =====
`timescale 1ns / 1ps
// Path: a request with frame_tick set passes the phase, sine, multiply and round cells in turn.
// Throughput: one frame per cycle; each cell of the chain holds one frame and
// passes it on when the next cell is free, so a stalled output only fills the chain.
// Reset: phase accumulator cleared, phase_step 0, amplitude_gain unity, chain empty.
// ----------------------------------------------------------------------------
// Sine DDS oscillator
// Phase accumulator, quarter-wave lookup, gain multiply and rounding in a
// chain of registered cells with stream handshakes on both sides.
// ----------------------------------------------------------------------------
module sine_dds_oscillator #(
    parameter int PHASE_BITS  = sdds_pkg::PHASE_BITS_DEF,
    parameter int TABLE_DEPTH = sdds_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS = sdds_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Configuration write port.
    input  logic                                    cfg_we,
    input  logic [0:0]                              cfg_index,
    input  logic [sdds_pkg::CFG_W-1:0]              cfg_wdata,
    // Request stream.
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [7:0]                              s_tdata,  // [0] frame_tick, rest zero
    input  logic                                    s_tlast,  // block_end
    // Frame stream.
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,  // left_sample, right_sample
    output logic                                    m_tlast   // last_frame
);
    import sdds_pkg::*;

    localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int P_W   = SINE_W + GAIN_W + 3;

    logic [STEP_W-1:0] step_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (sdds_reg_t'(cfg_index))
                REG_PHASE_STEP: step_reg <= cfg_wdata[STEP_W-1:0];
                REG_AMP_GAIN:   gain_reg <= cfg_wdata[GAIN_W-1:0];
                default:        ;
            endcase
        end
    end

    sdds_ctl_t                     ph_ctl;
    sdds_ctl_t                     sn_ctl;
    sdds_ctl_t                     ml_ctl;
    sdds_ctl_t                     rd_ctl;
    logic                          sn_ready;
    logic                          ml_ready;
    logic                          rd_ready;
    logic [PHASE_BITS-1:0]         ph_phase;
    logic [SINE_W-1:0]             sn_mag;
    logic                          sn_neg;
    logic signed [P_W-1:0]         ml_prod;
    logic signed [SAMPLE_BITS-1:0] rd_sample;

    sdds_phase_cell #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .phase_step (step_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .frame_tick (s_tdata[0]),
        .block_end  (s_tlast),
        .out_ctl    (ph_ctl),
        .out_ready  (sn_ready),
        .out_phase  (ph_phase)
    );

    sdds_sine_cell #(
        .PHASE_BITS  (PHASE_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (ph_ctl),
        .in_ready  (sn_ready),
        .in_phase  (ph_phase),
        .out_ctl   (sn_ctl),
        .out_ready (ml_ready),
        .out_mag   (sn_mag),
        .out_neg   (sn_neg)
    );

    sdds_mult_cell u_mult (
        .clk            (clk),
        .rst_n          (rst_n),
        .amplitude_gain (gain_reg),
        .in_ctl         (sn_ctl),
        .in_ready       (ml_ready),
        .in_mag         (sn_mag),
        .in_neg         (sn_neg),
        .out_ctl        (ml_ctl),
        .out_ready      (rd_ready),
        .out_prod       (ml_prod)
    );

    sdds_round_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (ml_ctl),
        .in_ready   (rd_ready),
        .in_prod    (ml_prod),
        .out_ctl    (rd_ctl),
        .out_ready  (m_tready),
        .out_sample (rd_sample)
    );

    // Both channels carry the same sample.
    assign m_tvalid = rd_ctl.valid;
    assign m_tlast  = rd_ctl.last;
    assign m_tdata  = OUT_W'({rd_sample, rd_sample});

endmodule

// ===== rtl/core/sdds_phase_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase accumulator cell
// Takes frame requests, latches the current phase and advances the accumulator.
// ----------------------------------------------------------------------------
module sdds_phase_cell #(
    parameter int PHASE_BITS = sdds_pkg::PHASE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sdds_pkg::STEP_W-1:0]   phase_step,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          frame_tick,
    input  logic                          block_end,
    output sdds_pkg::sdds_ctl_t           out_ctl,
    input  logic                          out_ready,
    output logic [PHASE_BITS-1:0]         out_phase
);
    import sdds_pkg::*;

    logic                  valid_reg;
    logic                  last_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] acc_reg;
    logic [PHASE_BITS-1:0] acc_next;
    logic                  take_frame;

    // The cell is free when empty or when its frame moves on this cycle.
    assign in_ready   = !valid_reg || out_ready;
    assign take_frame = in_valid && in_ready && frame_tick;
    assign acc_next   = acc_reg + PHASE_BITS'(phase_step);

    // Control state: occupancy and the running phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid && frame_tick;
            end
            if (take_frame)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // Payload: the phase before this frame's step.
    always_ff @(posedge clk)
    begin
        if (take_frame)
        begin
            phase_reg <= acc_reg;
            last_reg  <= block_end;
        end
    end

    assign out_ctl.valid = valid_reg;
    assign out_ctl.last  = last_reg;
    assign out_phase     = phase_reg;

endmodule

// ===== rtl/core/sdds_sine_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine lookup cell
// Folds the phase into a quarter wave and reads the sine magnitude table.
// ----------------------------------------------------------------------------
module sdds_sine_cell #(
    parameter int PHASE_BITS  = sdds_pkg::PHASE_BITS_DEF,
    parameter int TABLE_DEPTH = sdds_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdds_pkg::sdds_ctl_t           in_ctl,
    output logic                          in_ready,
    input  logic [PHASE_BITS-1:0]         in_phase,
    output sdds_pkg::sdds_ctl_t           out_ctl,
    input  logic                          out_ready,
    output logic [sdds_pkg::SINE_W-1:0]   out_mag,
    output logic                          out_neg
);
    import sdds_pkg::*;

    localparam int FRAC_W = PHASE_BITS - 2;
    localparam int IDX_W  = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W = FRAC_W + IDX_W;

    // Quarter-wave sine in Q1.15 from an eight-term series in Q2.30.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic [63:0]        q;
        x   = (HALF_PI_Q30 * 64'(i)) / 64'(TABLE_DEPTH);
        x2  = (x * x) >> 30;
        mag = x;
        sum = signed'(x);
        mag = ((mag * x2) >> 30) / 64'd6;
        sum = sum - signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd20;
        sum = sum + signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd42;
        sum = sum - signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd72;
        sum = sum + signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd110;
        sum = sum - signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd156;
        sum = sum + signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd210;
        sum = sum - signed'(mag);
        if (sum < 0)
        begin
            sum = '0;
        end
        q = (unsigned'(sum) + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return q[SINE_W-1:0];
    endfunction

    logic [SINE_W-1:0] rom [0:TABLE_DEPTH];

    // Constant table contents, fixed at elaboration.
    for (genvar g = 0; g <= TABLE_DEPTH; g++)
    begin : g_rom
        assign rom[g] = quarter_sine(g);
    end

    logic              valid_reg;
    logic              last_reg;
    logic              neg_reg;
    logic [SINE_W-1:0] mag_reg;
    logic [1:0]        quad;
    logic [PROD_W-1:0] idx_prod;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  addr;

    // Quadrant from the top bits, table index from the scaled fraction.
    assign quad     = in_phase[PHASE_BITS-1 -: 2];
    assign idx_prod = PROD_W'(in_phase[FRAC_W-1:0]) * PROD_W'(TABLE_DEPTH);
    assign idx      = idx_prod[PROD_W-1 -: IDX_W];
    assign addr     = quad[0] ? (IDX_W'(TABLE_DEPTH) - idx) : idx;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_ctl.valid;
        end
    end

    // Registered table read with the sign of the lower half wave.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_ctl.valid)
        begin
            mag_reg  <= rom[addr];
            neg_reg  <= quad[1];
            last_reg <= in_ctl.last;
        end
    end

    assign out_ctl.valid = valid_reg;
    assign out_ctl.last  = last_reg;
    assign out_mag       = mag_reg;
    assign out_neg       = neg_reg;

endmodule

// ===== rtl/core/sdds_mult_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain multiplier cell
// Applies the sign to the table value and multiplies by the amplitude gain.
// ----------------------------------------------------------------------------
module sdds_mult_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sdds_pkg::GAIN_W-1:0]   amplitude_gain,
    input  sdds_pkg::sdds_ctl_t           in_ctl,
    output logic                          in_ready,
    input  logic [sdds_pkg::SINE_W-1:0]   in_mag,
    input  logic                          in_neg,
    output sdds_pkg::sdds_ctl_t           out_ctl,
    input  logic                          out_ready,
    output logic signed [sdds_pkg::SINE_W+sdds_pkg::GAIN_W+2:0] out_prod
);
    import sdds_pkg::*;

    localparam int SS_W = SINE_W + 1;
    localparam int GS_W = GAIN_W + 1;
    localparam int P_W  = SINE_W + GAIN_W + 3;

    logic                   valid_reg;
    logic                   last_reg;
    logic signed [P_W-1:0]  prod_reg;
    logic signed [SS_W-1:0] sine_s;
    logic signed [GS_W-1:0] gain_s;
    logic signed [P_W-1:0]  prod;

    // Signed sine and zero-extended gain, then one 16x17 product.
    assign sine_s = in_neg ? -signed'({1'b0, in_mag}) : signed'({1'b0, in_mag});
    assign gain_s = signed'({1'b0, amplitude_gain});
    assign prod   = P_W'(sine_s) * P_W'(gain_s);

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ctl.valid)
        begin
            prod_reg <= prod;
            last_reg <= in_ctl.last;
        end
    end

    assign out_ctl.valid = valid_reg;
    assign out_ctl.last  = last_reg;
    assign out_prod      = prod_reg;

endmodule

// ===== rtl/core/sdds_round_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round and saturate cell
// Rounds the Q2.30 product half up to the sample width and clamps it.
// ----------------------------------------------------------------------------
module sdds_round_cell #(
    parameter int SAMPLE_BITS = sdds_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdds_pkg::sdds_ctl_t           in_ctl,
    output logic                          in_ready,
    input  logic signed [sdds_pkg::SINE_W+sdds_pkg::GAIN_W+2:0] in_prod,
    output sdds_pkg::sdds_ctl_t           out_ctl,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);
    import sdds_pkg::*;

    localparam int P_W   = SINE_W + GAIN_W + 3;
    localparam int SHIFT = 31 - SAMPLE_BITS;
    localparam logic signed [P_W-1:0] HALF   = P_W'(64'sd1 <<< (SHIFT - 1));
    localparam logic signed [P_W-1:0] SAT_HI = P_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [P_W-1:0] SAT_LO = P_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    logic                          valid_reg;
    logic                          last_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [P_W-1:0]         rounded;
    logic signed [SAMPLE_BITS-1:0] clamped;

    // Floor of (p + half) / 2^SHIFT, then clamp to the signed sample range.
    assign rounded = (in_prod + HALF) >>> SHIFT;

    always_comb
    begin
        if (rounded > SAT_HI)
        begin
            clamped = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (rounded < SAT_LO)
        begin
            clamped = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            clamped = rounded[SAMPLE_BITS-1:0];
        end
    end

    // Output register: holds a frame until the sink takes the transfer.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ctl.valid)
        begin
            sample_reg <= clamped;
            last_reg   <= in_ctl.last;
        end
    end

    assign out_ctl.valid = valid_reg;
    assign out_ctl.last  = last_reg;
    assign out_sample    = sample_reg;

endmodule
